>>> hw/rtl/bir_pkg.sv
// Shared types and constants for the bilinear image resize block.
// No dependencies.
`timescale 1ns / 1ps
package bir_pkg;

  typedef struct packed {
    logic        mode;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [1:0]  channel;
    logic [7:0]  sample_in;
  } bir_in_t;

  typedef struct packed {
    logic [7:0] sample_out;
    logic       range_error;
  } bir_out_t;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL = 2'd2;
  localparam logic [1:0] REG_SCALE   = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Reciprocal of the scale: 2^32 / s; 32 bits hold it for s >= 2, and the 33rd bit holds it for s == 1.
  localparam int RECIP_W = 33;

endpackage

>>> hw/rtl/bir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> hw/rtl/bir_recip.sv
// Iterative reciprocal unit: computes 2^32 / scale after reset (scale 256) and after each scale write.
// Depends on bir_pkg.
`timescale 1ns / 1ps
module bir_recip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [11:0]                   scale,
  output logic [bir_pkg::RECIP_W-1:0]   recip,
  output logic                          done
);
  import bir_pkg::*;

  logic [12:0]        rem_r, rem_nxt;
  logic [RECIP_W-1:0] quo_r, quo_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [11:0]        div_r;
  logic               busy_r, busy_nxt;
  logic [13:0]        trial;

  // Restoring division of 1<<32 by the scale, one quotient bit per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, (cnt_r == 6'd32)} - {2'b00, div_r};
    if (busy_r) begin
      if (!trial[13]) begin
        rem_nxt = trial[12:0];
        quo_nxt = {quo_r[RECIP_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[11:0], (cnt_r == 6'd32)};
        quo_nxt = {quo_r[RECIP_W-2:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
      rem_r  <= '0;
      quo_r  <= '0;
      div_r  <= 12'd256;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
      rem_r  <= '0;
      quo_r  <= '0;
      div_r  <= (scale == 12'd0) ? 12'd1 : scale;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign recip = quo_r;
  assign done  = !busy_r;
endmodule

>>> hw/rtl/bilinear_image_resize.sv
// Bilinear image resize: source store in four parity-banked RAMs, 6-stage read pipeline.
// A read result strobes on out_valid from the stage 6 output register; an out-of-range write likewise.
// Throughput: one item per cycle while busy is low; busy is high only while the scale
// reciprocal is recomputed, after reset and after each scale write.
// Reset: synchronous active-low; registers return to their reset values, store undefined.
// The receiver cannot stall; results strobe for one cycle on out_valid.
`timescale 1ns / 1ps
module bilinear_image_resize #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bir_pkg::bir_in_t  in_data,
  output logic              out_valid,
  output bir_pkg::bir_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data
);
  import bir_pkg::*;

  localparam int BW_HALF = MAX_WIDTH / 2 + MAX_WIDTH % 2;
  localparam int BH_HALF = MAX_HEIGHT / 2 + MAX_HEIGHT % 2;
  localparam int BDEPTH  = BW_HALF * BH_HALF * MAX_CHANNELS;
  localparam int BAW     = $clog2(BDEPTH);

  // Configuration registers
  logic [8:0]  src_w_r;
  logic [8:0]  src_h_r;
  logic [2:0]  nch_r;
  logic [11:0] scale_r;
  logic        cfg_fire;
  logic        recip_done;
  logic [RECIP_W-1:0] recip;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256;
      src_h_r <= 9'd256;
      nch_r   <= 3'd3;
      scale_r <= 12'd256;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_WIDTH:   src_w_r <= cfg_data[8:0];
        REG_HEIGHT:  src_h_r <= cfg_data[8:0];
        REG_CHANNEL: nch_r   <= cfg_data[2:0];
        REG_SCALE:   scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bir_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cfg_fire && (cfg_index == REG_SCALE)),
    .scale (cfg_data),
    .recip (recip),
    .done  (recip_done)
  );

  assign busy = !recip_done;

  // Clamped register values (widths padded to 13 bits for MAX up to 4096)
  logic [12:0] w_c, h_c;
  logic [2:0]  nc_c;
  logic [11:0] s_c;
  always_comb begin
    w_c  = (src_w_r == 9'd0) ? 13'd1 : {4'd0, src_w_r};
    if (w_c > 13'(MAX_WIDTH)) w_c = 13'(MAX_WIDTH);
    h_c  = (src_h_r == 9'd0) ? 13'd1 : {4'd0, src_h_r};
    if (h_c > 13'(MAX_HEIGHT)) h_c = 13'(MAX_HEIGHT);
    nc_c = (nch_r == 3'd0) ? 3'd1 : nch_r;
    if (nc_c > 3'(MAX_CHANNELS)) nc_c = 3'(MAX_CHANNELS);
    s_c  = (scale_r == 12'd0) ? 12'd1 : scale_r;
  end

  // Destination size from the current registers
  logic [20:0] dw, dh;
  assign dw = 21'((25'(s_c) * 25'(w_c)) >> 8);
  assign dh = 21'((25'(s_c) * 25'(h_c)) >> 8);

  logic acc;
  assign acc = start && !busy;

  // Stage 1: range check and quotient estimate via reciprocal multiply
  logic        v1_r, mode1_r, err1_r;
  logic [11:0] x1_r, y1_r;
  logic [1:0]  c1_r;
  logic [7:0]  d1_r;
  logic [44:0] qx1_r, qy1_r;
  logic        werr, rerr;

  assign werr = (13'(in_data.pos_x) >= w_c) || (13'(in_data.pos_y) >= h_c) ||
                (3'(in_data.channel) >= nc_c);
  assign rerr = (21'(in_data.pos_x) >= dw) || (21'(in_data.pos_y) >= dh) ||
                (3'(in_data.channel) >= nc_c);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= acc;
    mode1_r <= in_data.mode;
    err1_r  <= (in_data.mode == MODE_WRITE) ? werr : rerr;
    x1_r    <= in_data.pos_x;
    y1_r    <= in_data.pos_y;
    c1_r    <= in_data.channel;
    d1_r    <= in_data.sample_in;
    qx1_r   <= 45'(recip[RECIP_W-2:0]) * 45'(in_data.pos_x);
    qy1_r   <= 45'(recip[RECIP_W-2:0]) * 45'(in_data.pos_y);
  end

  // Stage 2: correct estimate. q_est = floor(n*floor(2^32/s)/2^32)*... using n<<16.
  // q_est is exact or one low; fix with one compare of the remainder and an increment.
  logic [27:0] ex, ey;
  logic [11:0] s_use;
  assign s_use = s_c;
  logic [27:0] nx, ny;
  assign nx = {x1_r, 16'd0};
  assign ny = {y1_r, 16'd0};
  always_comb begin
    ex = (s_use == 12'd1) ? nx : 28'(qx1_r >> 16);
    ey = (s_use == 12'd1) ? ny : 28'(qy1_r >> 16);
  end

  logic        v2_r, mode2_r, err2_r;
  logic [11:0] x2_r, y2_r;
  logic [1:0]  c2_r;
  logic [7:0]  d2_r;
  logic [27:0] ex2_r, ey2_r;
  logic [39:0] px2_r, py2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    mode2_r <= mode1_r; err2_r <= err1_r;
    x2_r <= x1_r; y2_r <= y1_r; c2_r <= c1_r; d2_r <= d1_r;
    ex2_r <= ex; ey2_r <= ey;
    px2_r <= 40'(ex) * 40'(s_use);
    py2_r <= 40'(ey) * 40'(s_use);
  end

  logic [27:0] sx, sy;
  always_comb begin
    sx = ex2_r;
    sy = ey2_r;
    if (40'({x2_r, 16'd0}) - px2_r >= 40'(s_use)) sx = ex2_r + 28'd1;
    if (40'({y2_r, 16'd0}) - py2_r >= 40'(s_use)) sy = ey2_r + 28'd1;
  end

  // Stage 3: neighbours, clamps, bank addresses; write path issues here
  logic [19:0] xi, yi;
  logic [12:0] x0, y0, xx1, yy1;
  always_comb begin
    xi  = sx[27:8];
    yi  = sy[27:8];
    x0  = (xi >= 20'(w_c)) ? w_c - 13'd1 : xi[12:0];
    y0  = (yi >= 20'(h_c)) ? h_c - 13'd1 : yi[12:0];
    xx1 = (x0 + 13'd1 >= w_c) ? w_c - 13'd1 : x0 + 13'd1;
    yy1 = (y0 + 13'd1 >= h_c) ? h_c - 13'd1 : y0 + 13'd1;
  end

  // Bank b = {y parity, x parity}. For each bank choose the column/row of matching parity.
  logic [12:0] bx [2];
  logic [12:0] by [2];
  always_comb begin
    bx[0] = (x0[0] == 1'b0) ? x0 : xx1;
    bx[1] = (x0[0] == 1'b1) ? x0 : xx1;
    by[0] = (y0[0] == 1'b0) ? y0 : yy1;
    by[1] = (y0[0] == 1'b1) ? y0 : yy1;
  end

  function automatic logic [BAW-1:0] baddr(input logic [12:0] x, input logic [12:0] y,
                                           input logic [1:0] c);
    logic [31:0] a;
    a = ((32'(y >> 1) * 32'(BW_HALF)) + 32'(x >> 1)) * 32'(MAX_CHANNELS) + 32'(c);
    return a[BAW-1:0];
  endfunction

  logic        ram_we [4];
  logic [BAW-1:0] ram_wa, ram_ra [4];
  logic [7:0]  ram_rd [4];
  logic        wr_go;
  assign wr_go = v2_r && (mode2_r == MODE_WRITE) && !err2_r;
  assign ram_wa = baddr(13'(x2_r), 13'(y2_r), c2_r);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign ram_we[b] = wr_go && (x2_r[0] == b[0]) && (y2_r[0] == b[1]);
    assign ram_ra[b] = baddr(bx[b % 2], by[b / 2], c2_r);
    bir_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_ram (
      .clk     (clk),
      .wr_en   (ram_we[b]),
      .wr_addr (ram_wa),
      .wr_data (d2_r),
      .rd_addr (ram_ra[b]),
      .rd_data (ram_rd[b])
    );
  end

  // Stage 3 registers (RAM read in flight)
  logic       v3_r, mode3_r, err3_r, x0p_r, y0p_r, xcl_r, ycl_r;
  logic [7:0] fx3_r, fy3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    mode3_r <= mode2_r; err3_r <= err2_r;
    fx3_r <= sx[7:0]; fy3_r <= sy[7:0];
    x0p_r <= x0[0]; y0p_r <= y0[0];
    xcl_r <= (xx1 == x0); ycl_r <= (yy1 == y0);
  end

  // Stage 4: route bank data to p00/p01/p10/p11, weight products
  // At a clamped edge the far neighbour is the near one, so take it from the same bank.
  logic       x1p, y1p;
  logic [7:0] p00, p01, p10, p11;
  always_comb begin
    x1p = xcl_r ? x0p_r : !x0p_r;
    y1p = ycl_r ? y0p_r : !y0p_r;
    p00 = ram_rd[{y0p_r, x0p_r}];
    p10 = ram_rd[{y0p_r, x1p}];
    p01 = ram_rd[{y1p, x0p_r}];
    p11 = ram_rd[{y1p, x1p}];
  end
  logic       v4_r, mode4_r, err4_r;
  logic [8:0] wy1_r, wy0_r;
  logic [16:0] a00_r, a01_r, a10_r, a11_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    mode4_r <= mode3_r; err4_r <= err3_r;
    wy1_r <= {1'b0, fy3_r};
    wy0_r <= 9'd256 - {1'b0, fy3_r};
    a11_r <= 17'(p11) * 17'(fx3_r);
    a10_r <= 17'(p10) * 17'(fx3_r);
    a01_r <= 17'(p01) * (17'd256 - 17'(fx3_r));
    a00_r <= 17'(p00) * (17'd256 - 17'(fx3_r));
  end

  // Stage 5: multiply by vertical weights and sum
  logic       v5_r, mode5_r, err5_r;
  logic [26:0] sum5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    mode5_r <= mode4_r; err5_r <= err4_r;
    sum5_r <= 27'(a11_r) * 27'(wy1_r) + 27'(a10_r) * 27'(wy0_r)
            + 27'(a01_r) * 27'(wy1_r) + 27'(a00_r) * 27'(wy0_r);
  end

  // Stage 6: output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v5_r && ((mode5_r == MODE_READ) || err5_r);
    out_data.sample_out  <= err5_r ? 8'd0 : sum5_r[23:16];
    out_data.range_error <= err5_r;
  end

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(cfg_fire)) else $error("busy rose without a scale write");
  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v5_r)) else $error("result without request");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |-> (out_data.sample_out == 8'd0))
    else $error("error result carries data");
`endif
endmodule
